@@ hdl/chse_pkg.sv @@
// Shared types, codes and constants for the cubic Hermite spline evaluator.
// No dependencies; every other file in hdl/ except chse_ram imports this package.
package chse_pkg;

  // Fixed field widths of the item and result ports
  localparam int WORD_W   = 32;
  localparam int CMD_W    = 2;
  localparam int IDX_W    = 5;
  localparam int CNT_W    = 6;
  localparam int STATUS_W = 2;

  // Defaults handed to the top-level parameters
  localparam int MAX_KNOTS_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Q-format and datapath widths
  localparam int FRAC_BITS = 16;
  localparam int U_W       = FRAC_BITS + 1;  // u, u^2, u^3 in [0, 1.0]
  localparam int H_W       = FRAC_BITS + 4;  // signed basis weights
  localparam int MUL_W     = 34;             // shared multiplier operand width
  localparam int PROD_W    = 2 * MUL_W;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD_POS   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_VAL   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_SLOPE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_EVAL       = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_KNOTS   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_WIDTH = 2'd2;

  // One classified item as it travels from the front to the back
  typedef struct packed {
    logic                     is_eval;
    logic                     load_ok;
    logic [CMD_W-1:0]         cmd;
    logic [IDX_W-1:0]         knot_index;
    logic signed [WORD_W-1:0] operand;
  } item_t;

  // Saturate a wide signed value to the signed 32-bit range
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(64'sh7FFF_FFFF);
    lo = -PROD_W'(64'sh8000_0000);
    if (v > hi) return WORD_W'(hi);
    if (v < lo) return WORD_W'(lo);
    return WORD_W'(v);
  endfunction

endpackage

@@ hdl/chse_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module chse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/chse_front.sv @@
// Front end: accepts items, classifies them and holds them in a short queue.
// Depends on chse_pkg.
module chse_front
  import chse_pkg::*;
#(
  parameter int MAX_KNOTS = MAX_KNOTS_DEF,
  parameter int DEPTH     = QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [CMD_W-1:0]         cmd,
  input  logic [IDX_W-1:0]         knot_index,
  input  logic signed [WORD_W-1:0] operand,
  output item_t                    head,
  output logic                     head_valid,
  input  logic                     head_pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  fill;
  item_t          incoming;
  logic           do_push;
  logic           do_pop;

  // Classify the incoming item
  always_comb begin
    incoming.is_eval    = (cmd == CMD_EVAL);
    incoming.load_ok    = (32'(knot_index) < MAX_KNOTS);
    incoming.cmd        = cmd;
    incoming.knot_index = knot_index;
    incoming.operand    = operand;
  end

  assign full       = (fill == CW'(DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = head_pop && head_valid;

  // Advance pointers and fill count on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= incoming;
    end
  end

endmodule

@@ hdl/chse_back.sv @@
// Back end: knot tables, interval search, u divider, Hermite blend and result register.
// Depends on chse_pkg and chse_ram.
module chse_back
  import chse_pkg::*;
#(
  parameter int MAX_KNOTS = MAX_KNOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [CNT_W-1:0]           knot_count,
  input  item_t                      item,
  input  logic                       item_valid,
  output logic                       item_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [WORD_W-1:0]   y_value,
  output logic [STATUS_W-1:0]        status
);

  localparam int AW   = $clog2(MAX_KNOTS);
  localparam int NW0  = $clog2(MAX_KNOTS + 1);
  localparam int NW   = (NW0 > CNT_W) ? NW0 : CNT_W;
  localparam int DCW  = $clog2(FRAC_BITS + 1);
  localparam int MAGW = WORD_W + 2;

  typedef enum logic [4:0] {
    IDLE, CHK0_W, CHK0, CHKN_W, CHKN, SRCH_STEP, SRCH_W, SRCH,
    FL_W, FL, FR_W, FR, DIV, LIN_MUL, LIN_OUT,
    H_U2, H_U2S, H_U3, H_U3S, H_BASIS, H_V0, H_V1, H_VSUM, H_S1, H_SSUM, H_SW, H_OUT
  } state_t;

  state_t                    state;
  logic [AW-1:0]             rd_addr;
  logic signed [WORD_W-1:0]  x_reg;
  logic [NW-1:0]             n_last;
  logic [NW-1:0]             lo;
  logic [NW-1:0]             k;
  logic [NW-1:0]             mid;
  logic signed [WORD_W-1:0]  pl;
  logic signed [WORD_W-1:0]  vl;
  logic signed [WORD_W-1:0]  sl;
  logic signed [WORD_W-1:0]  vr;
  logic signed [WORD_W-1:0]  sr;
  logic signed [WORD_W:0]    w;
  logic [MAGW-1:0]           rem;
  logic [MAGW-1:0]           wmag;
  logic [FRAC_BITS-1:0]      qbits;
  logic [DCW-1:0]            div_cnt;
  logic [U_W-1:0]            u;
  logic [U_W-1:0]            u2;
  logic [U_W-1:0]            u3;
  logic signed [H_W-1:0]     h00;
  logic signed [H_W-1:0]     h10;
  logic signed [H_W-1:0]     h01;
  logic signed [H_W-1:0]     h11;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  acc;
  logic signed [PROD_W-1:0]  a_val;
  logic signed [WORD_W-1:0]  s_val;
  logic                      out_valid;

  logic [WORD_W-1:0]         rd_pos;
  logic [WORD_W-1:0]         rd_val;
  logic [WORD_W-1:0]         rd_slope;
  logic signed [WORD_W-1:0]  p_rd;
  logic [NW-1:0]             n_eff;
  logic                      res_free;
  logic                      res_set;
  logic                      load_go;
  logic [AW-1:0]             waddr;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [WORD_W:0]    dx;
  logic signed [WORD_W:0]    w_new;
  logic signed [MAGW-1:0]    d_ext;
  logic signed [MAGW-1:0]    w_ext;
  logic [MAGW-1:0]           d_mag;
  logic [MAGW-1:0]           w_mag;
  logic [MAGW:0]             rem2;
  logic                      qbit;
  logic [NW:0]               mid_sum;
  logic                      more_steps;
  logic signed [PROD_W-1:0]  pair_sum;
  logic signed [PROD_W-1:0]  pair_shift;
  logic signed [PROD_W-1:0]  prod_shift;
  logic signed [H_W-1:0]     su;
  logic signed [H_W-1:0]     su2;
  logic signed [H_W-1:0]     su3;

  // Knot tables, one read address shared by all three
  assign load_go = (state == IDLE) && item_valid && !item.is_eval && item.load_ok;
  assign waddr   = AW'(item.knot_index);

  chse_ram #(.WIDTH(WORD_W), .DEPTH(MAX_KNOTS)) u_pos_ram (
    .clk(clk), .we(load_go && (item.cmd == CMD_LOAD_POS)), .waddr(waddr),
    .wdata(item.operand), .raddr(rd_addr), .rdata(rd_pos)
  );
  chse_ram #(.WIDTH(WORD_W), .DEPTH(MAX_KNOTS)) u_val_ram (
    .clk(clk), .we(load_go && (item.cmd == CMD_LOAD_VAL)), .waddr(waddr),
    .wdata(item.operand), .raddr(rd_addr), .rdata(rd_val)
  );
  chse_ram #(.WIDTH(WORD_W), .DEPTH(MAX_KNOTS)) u_slope_ram (
    .clk(clk), .we(load_go && (item.cmd == CMD_LOAD_SLOPE)), .waddr(waddr),
    .wdata(item.operand), .raddr(rd_addr), .rdata(rd_slope)
  );

  // Effective knot count and result slot
  assign n_eff    = (NW'(knot_count) > NW'(MAX_KNOTS)) ? NW'(MAX_KNOTS) : NW'(knot_count);
  assign res_free = !out_valid || pop;
  assign empty    = !out_valid;
  assign p_rd     = $signed(rd_pos);

  // Take an item: loads and evaluations with knots go at once, others need the result slot
  always_comb begin
    item_pop = 1'b0;
    if ((state == IDLE) && item_valid) begin
      if (item.is_eval && (n_eff == '0)) begin
        item_pop = res_free;
      end else begin
        item_pop = 1'b1;
      end
    end
  end

  // Fill the result slot when a finished evaluation meets a free slot
  always_comb begin
    res_set = 1'b0;
    if (res_free) begin
      case (state)
        IDLE:           res_set = item_valid && item.is_eval && (n_eff == '0);
        FR:             res_set = (w_new == '0);
        LIN_OUT, H_OUT: res_set = 1'b1;
        default:        res_set = 1'b0;
      endcase
    end
  end

  // Search, divider and basis helpers
  always_comb begin
    mid_sum    = {1'b0, lo} + {1'b0, k};
    more_steps = ({1'b0, k} > ({1'b0, lo} + (NW + 1)'(1)));
    dx         = (WORD_W + 1)'(x_reg) - (WORD_W + 1)'(pl);
    w_new      = (WORD_W + 1)'(p_rd) - (WORD_W + 1)'(pl);
    d_ext      = MAGW'(dx);
    w_ext      = MAGW'(w_new);
    d_mag      = (d_ext < 0) ? MAGW'(-d_ext) : MAGW'(d_ext);
    w_mag      = (w_ext < 0) ? MAGW'(-w_ext) : MAGW'(w_ext);
    rem2       = {rem, 1'b0};
    qbit       = (rem2 >= {1'b0, wmag});
    pair_sum   = acc + prod;
    pair_shift = pair_sum >>> FRAC_BITS;
    prod_shift = prod >>> FRAC_BITS;
    su         = H_W'(u);
    su2        = H_W'(u2);
    su3        = H_W'(u3);
  end

  // Shared multiplier operands; hold them while the result waits for the slot
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      LIN_MUL, LIN_OUT: begin
        mul_a = MUL_W'(sl);
        mul_b = MUL_W'(dx);
      end
      H_U2: begin
        mul_a = MUL_W'(u);
        mul_b = MUL_W'(u);
      end
      H_U3: begin
        mul_a = MUL_W'(u2);
        mul_b = MUL_W'(u);
      end
      H_V0: begin
        mul_a = MUL_W'(vl);
        mul_b = MUL_W'(h00);
      end
      H_V1: begin
        mul_a = MUL_W'(vr);
        mul_b = MUL_W'(h01);
      end
      H_VSUM: begin
        mul_a = MUL_W'(sl);
        mul_b = MUL_W'(h10);
      end
      H_S1: begin
        mul_a = MUL_W'(sr);
        mul_b = MUL_W'(h11);
      end
      H_SW, H_OUT: begin
        mul_a = MUL_W'(s_val);
        mul_b = MUL_W'(w);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Multiplier output register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (res_set) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (item_valid && item.is_eval) begin
            x_reg  <= item.operand;
            n_last <= n_eff - 1'b1;
            if (n_eff == '0) begin
              if (res_free) begin
                y_value <= '0;
                status  <= STATUS_NO_KNOTS;
              end
            end else begin
              rd_addr <= '0;
              state   <= CHK0_W;
            end
          end
        end
        CHK0_W: state <= CHK0;
        CHK0: begin
          // Below or at the first knot: extrapolate from it
          if (x_reg <= p_rd) begin
            pl    <= p_rd;
            vl    <= $signed(rd_val);
            sl    <= $signed(rd_slope);
            state <= LIN_MUL;
          end else begin
            rd_addr <= AW'(n_last);
            state   <= CHKN_W;
          end
        end
        CHKN_W: state <= CHKN;
        CHKN: begin
          // At or above the last knot: extrapolate from it
          if (x_reg >= p_rd) begin
            pl    <= p_rd;
            vl    <= $signed(rd_val);
            sl    <= $signed(rd_slope);
            state <= LIN_MUL;
          end else begin
            lo    <= '0;
            k     <= n_last;
            state <= SRCH_STEP;
          end
        end
        SRCH_STEP: begin
          if (more_steps) begin
            mid     <= mid_sum[NW:1];
            rd_addr <= AW'(mid_sum[NW:1]);
            state   <= SRCH_W;
          end else begin
            rd_addr <= AW'(k - 1'b1);
            state   <= FL_W;
          end
        end
        SRCH_W: state <= SRCH;
        SRCH: begin
          if (x_reg < p_rd) begin
            k <= mid;
          end else begin
            lo <= mid;
          end
          state <= SRCH_STEP;
        end
        FL_W: state <= FL;
        FL: begin
          pl      <= p_rd;
          vl      <= $signed(rd_val);
          sl      <= $signed(rd_slope);
          rd_addr <= AW'(k);
          state   <= FR_W;
        end
        FR_W: state <= FR;
        FR: begin
          vr <= $signed(rd_val);
          sr <= $signed(rd_slope);
          w  <= w_new;
          if (w_new == '0) begin
            // Zero-width interval: report and drop
            if (res_free) begin
              y_value <= '0;
              status  <= STATUS_ZERO_WIDTH;
              state   <= IDLE;
            end
          end else if ((dx == '0) || ((d_ext < 0) != (w_ext < 0))) begin
            u     <= '0;
            state <= H_U2;
          end else if (d_mag >= w_mag) begin
            u     <= U_W'(1) << FRAC_BITS;
            state <= H_U2;
          end else begin
            rem     <= d_mag;
            wmag    <= w_mag;
            qbits   <= '0;
            div_cnt <= '0;
            state   <= DIV;
          end
        end
        DIV: begin
          // One quotient bit per cycle
          rem     <= qbit ? MAGW'(rem2 - {1'b0, wmag}) : MAGW'(rem2);
          qbits   <= {qbits[FRAC_BITS-2:0], qbit};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DCW'(FRAC_BITS - 1)) begin
            u     <= {1'b0, qbits[FRAC_BITS-2:0], qbit};
            state <= H_U2;
          end
        end
        LIN_MUL: state <= LIN_OUT;
        LIN_OUT: begin
          if (res_free) begin
            y_value <= sat_word(PROD_W'(vl) + prod_shift);
            status  <= STATUS_OK;
            state   <= IDLE;
          end
        end
        H_U2:  state <= H_U2S;
        H_U2S: begin
          u2    <= prod[FRAC_BITS +: U_W];
          state <= H_U3;
        end
        H_U3:  state <= H_U3S;
        H_U3S: begin
          u3    <= prod[FRAC_BITS +: U_W];
          state <= H_BASIS;
        end
        H_BASIS: begin
          h00   <= H_W'(2 * su3 - 3 * su2 + (H_W'(1) << FRAC_BITS));
          h10   <= H_W'(su3 - 2 * su2 + su);
          h01   <= H_W'(3 * su2 - 2 * su3);
          h11   <= su3 - su2;
          state <= H_V0;
        end
        H_V0: state <= H_V1;
        H_V1: begin
          acc   <= prod;
          state <= H_VSUM;
        end
        H_VSUM: begin
          a_val <= pair_shift;
          state <= H_S1;
        end
        H_S1: begin
          acc   <= prod;
          state <= H_SSUM;
        end
        H_SSUM: begin
          // Clamp the slope term to plus or minus 2^30
          if (pair_shift > PROD_W'(64'sh4000_0000)) begin
            s_val <= WORD_W'(64'sh4000_0000);
          end else if (pair_shift < -PROD_W'(64'sh4000_0000)) begin
            s_val <= -WORD_W'(64'sh4000_0000);
          end else begin
            s_val <= WORD_W'(pair_shift);
          end
          state <= H_SW;
        end
        H_SW: state <= H_OUT;
        H_OUT: begin
          if (res_free) begin
            y_value <= sat_word(a_val + prod_shift);
            status  <= STATUS_OK;
            state   <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

@@ hdl/cubic_hermite_spline_eval.sv @@
// Cubic Hermite spline evaluator, Q16.16. Loads with an in-range index are written to
// the knot tables as the back end takes them. Evaluate: below the first knot or at or
// above the last, extrapolate linearly from that knot; inside, a binary table search
// finds the interval, then the u divider runs unless u needs no division; items go one
// at a time through the back end while the front queue keeps accepting until full.
// Synchronous reset empties both queues and clears knot_count; knot tables are not cleared.
module cubic_hermite_spline_eval
  import chse_pkg::*;
#(
  parameter int MAX_KNOTS   = MAX_KNOTS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [CMD_W-1:0]           cmd,
  input  logic [IDX_W-1:0]           knot_index,
  input  logic signed [WORD_W-1:0]   operand,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [WORD_W-1:0]   y_value,
  output logic [STATUS_W-1:0]        status,
  input  logic                       cfg_wr_en,
  input  logic [CNT_W-1:0]           cfg_wr_data
);

  logic [CNT_W-1:0] knot_count;
  item_t            head;
  logic             head_valid;
  logic             head_pop;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      knot_count <= '0;
    end else if (cfg_wr_en) begin
      knot_count <= cfg_wr_data;
    end
  end

  chse_front #(.MAX_KNOTS(MAX_KNOTS), .DEPTH(QUEUE_DEPTH)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd),
    .knot_index(knot_index), .operand(operand),
    .head(head), .head_valid(head_valid), .head_pop(head_pop)
  );

  chse_back #(.MAX_KNOTS(MAX_KNOTS)) u_back (
    .clk(clk), .rst(rst), .knot_count(knot_count),
    .item(head), .item_valid(head_valid), .item_pop(head_pop),
    .empty(empty), .pop(pop), .y_value(y_value), .status(status)
  );

  // Both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // Error results carry a zero value
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && (status != STATUS_OK)) |-> (y_value == '0))
    else $error("error result with nonzero value");

  // The status code is one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (status == STATUS_OK || status == STATUS_NO_KNOTS ||
                status == STATUS_ZERO_WIDTH))
    else $error("undefined status code");

endmodule
